// ----- src/delimiter_tokenizer_macros.svh -----
// ----------------------------------------------------------------------------
// Delimiter tokenizer assertion macros
// Shared concurrent assertion forms for the stream checker.
// ----------------------------------------------------------------------------
`ifndef DELIMITER_TOKENIZER_MACROS_SVH
`define DELIMITER_TOKENIZER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset
`define DT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("delimiter_tokenizer assertion failed");

// Next-cycle implication, sampled on clk, off during reset
`define DT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("delimiter_tokenizer assertion failed");

`endif

// ----- src/dtok_pkg.sv -----
// ----------------------------------------------------------------------------
// Delimiter tokenizer package
// Result kinds, register indexes, queue entry type and sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package dtok_pkg;

    // Result kinds as seen on the output tuser
    typedef enum logic [1:0] {
        KIND_BYTE = 2'd0,
        KIND_END  = 2'd1,
        KIND_DONE = 2'd2
    } kind_t;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_DELIM_0     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DELIM_1     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DELIM_2     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DELIM_3     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ALLOW_EMPTY = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_TOKENS  = 3'd5;

    localparam int CFG_DATA_W = 64;
    localparam int LIMIT_W    = 16;
    localparam int IDX_W      = 16;
    localparam int BYTE_W     = 8;

    // Queue between classifier and output sequencer (power of two)
    localparam int QUEUE_DEPTH = 4;

    // One classified input: one result, or a token end followed by done
    typedef struct packed {
        logic              two;
        kind_t             kind0;
        logic [BYTE_W-1:0] byte0;
        logic [IDX_W-1:0]  idx0;
        logic [IDX_W-1:0]  idx1;
    } job_t;

endpackage

`default_nettype wire

// ----- src/dtok_fifo.sv -----
// ----------------------------------------------------------------------------
// Delimiter tokenizer job queue
// Small register queue decoupling the classifier from the output side.
// ----------------------------------------------------------------------------
`default_nettype none

module dtok_fifo (
    input  wire            clk,
    input  wire            rst_n,
    input  wire            push,
    input  dtok_pkg::job_t wr_job,
    output logic           full,
    input  wire            pop,
    output logic           empty,
    output dtok_pkg::job_t rd_job
);
    import dtok_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    job_t             q_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_job  = q_reg[rd_ptr_reg];

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= wr_job;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- src/dtok_front.sv -----
// ----------------------------------------------------------------------------
// Delimiter tokenizer classifier
// Holds the configuration, looks up each byte in the delimiter bitmap, runs
// the scan state and token counter, and queues the results of each input.
// ----------------------------------------------------------------------------
`default_nettype none

module dtok_front #(
    parameter int COUNT_WIDTH = 16
) (
    input  wire                            clk,
    input  wire                            rst_n,
    // configuration writes
    input  wire                            cfg_valid,
    output logic                           cfg_ready,
    input  wire [dtok_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire [dtok_pkg::CFG_DATA_W-1:0] cfg_data,
    // input items
    input  wire                            in_valid,
    output logic                           in_ready,
    input  wire [dtok_pkg::BYTE_W-1:0]     ch,
    input  wire                            is_end,
    // queue write side
    output logic                           push,
    output dtok_pkg::job_t                 job,
    input  wire                            full
);
    import dtok_pkg::*;

    localparam int CMP_W = (COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W;
    localparam int EXT_W = (CMP_W > IDX_W) ? CMP_W : IDX_W;

    typedef enum logic [3:0] {
        MODE_START = 4'b0001,
        MODE_SKIP  = 4'b0010,
        MODE_TOKEN = 4'b0100,
        MODE_REST  = 4'b1000
    } mode_t;

    logic [4*CFG_DATA_W-1:0] delim_reg;
    logic                    allow_empty_reg;
    logic [LIMIT_W-1:0]      max_tokens_reg;
    mode_t                   mode_reg, mode_next;
    logic [COUNT_WIDTH-1:0]  count_reg, count_next;

    logic                    accept;
    logic                    is_delim;
    logic                    at_limit;
    logic [COUNT_WIDTH-1:0]  count_inc;
    logic [EXT_W-1:0]        count_ext;
    logic [EXT_W-1:0]        inc_ext;

    assign cfg_ready = 1'b1;
    assign in_ready  = !full;
    assign accept    = in_valid && !full;

    // Bitmap lookup and limit test
    assign is_delim  = delim_reg[ch];
    assign at_limit  = (max_tokens_reg != '0) &&
                       (CMP_W'(count_reg) == CMP_W'(max_tokens_reg) - CMP_W'(1));
    assign count_inc = (count_reg != '1) ? count_reg + 1'b1 : count_reg;
    assign count_ext = EXT_W'(count_reg);
    assign inc_ext   = EXT_W'(count_inc);

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delim_reg       <= '0;
            allow_empty_reg <= 1'b0;
            max_tokens_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_DELIM_0:     delim_reg[0*CFG_DATA_W +: CFG_DATA_W] <= cfg_data;
                REG_DELIM_1:     delim_reg[1*CFG_DATA_W +: CFG_DATA_W] <= cfg_data;
                REG_DELIM_2:     delim_reg[2*CFG_DATA_W +: CFG_DATA_W] <= cfg_data;
                REG_DELIM_3:     delim_reg[3*CFG_DATA_W +: CFG_DATA_W] <= cfg_data;
                REG_ALLOW_EMPTY: allow_empty_reg <= cfg_data[0];
                REG_MAX_TOKENS:  max_tokens_reg  <= cfg_data[LIMIT_W-1:0];
                default:         ;
            endcase
        end
    end

    // Classification and scan state transition
    always_comb
    begin
        mode_next  = mode_reg;
        count_next = count_reg;
        push       = 1'b0;
        job.two    = 1'b0;
        job.kind0  = KIND_BYTE;
        job.byte0  = ch;
        job.idx0   = count_ext[IDX_W-1:0];
        job.idx1   = inc_ext[IDX_W-1:0];

        if (is_end)
        begin
            // close an open token (or an empty final one), then string done
            push       = accept;
            job.byte0  = '0;
            mode_next  = MODE_START;
            count_next = '0;
            if (mode_reg == MODE_TOKEN || mode_reg == MODE_REST ||
                (mode_reg == MODE_SKIP && at_limit))
            begin
                job.two   = 1'b1;
                job.kind0 = KIND_END;
            end
            else
            begin
                job.kind0 = KIND_DONE;
            end
        end
        else
        begin
            unique case (mode_reg)
                MODE_REST:
                begin
                    push = accept;
                end
                MODE_TOKEN:
                begin
                    push = accept;
                    if (is_delim)
                    begin
                        job.kind0  = KIND_END;
                        job.byte0  = '0;
                        count_next = count_inc;
                        mode_next  = MODE_START;
                    end
                end
                MODE_START, MODE_SKIP:
                begin
                    if (is_delim && !allow_empty_reg)
                    begin
                        mode_next = MODE_SKIP;
                    end
                    else if (at_limit)
                    begin
                        push      = accept;
                        mode_next = MODE_REST;
                    end
                    else if (is_delim)
                    begin
                        // empty token closed by this delimiter
                        push       = accept;
                        job.kind0  = KIND_END;
                        job.byte0  = '0;
                        count_next = count_inc;
                        mode_next  = MODE_START;
                    end
                    else
                    begin
                        push      = accept;
                        mode_next = MODE_TOKEN;
                    end
                end
                default:
                begin
                    mode_next = MODE_START;
                end
            endcase
        end
    end

    // Scan state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_START;
            count_reg <= '0;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/dtok_back.sv -----
// ----------------------------------------------------------------------------
// Delimiter tokenizer output sequencer
// Drains queued jobs into the output register, one result per transaction,
// splitting a token-end plus done job into two results.
// ----------------------------------------------------------------------------
`default_nettype none

module dtok_back (
    input  wire                        clk,
    input  wire                        rst_n,
    // queue read side
    input  wire                        empty,
    input  dtok_pkg::job_t             rd_job,
    output logic                       pop,
    // result stream
    output logic                       out_valid,
    input  wire                        out_ready,
    output dtok_pkg::kind_t            kind,
    output logic [dtok_pkg::BYTE_W-1:0] byte_out,
    output logic [dtok_pkg::IDX_W-1:0] token_index,
    output logic                       last
);
    import dtok_pkg::*;

    typedef enum logic [1:0] {
        PH_FIRST  = 2'b01,
        PH_SECOND = 2'b10
    } phase_t;

    phase_t             phase_reg;
    logic               out_valid_reg;
    kind_t              kind_reg;
    logic [BYTE_W-1:0]  byte_reg;
    logic [IDX_W-1:0]   index_reg;
    logic               last_reg;
    logic [IDX_W-1:0]   done_idx_reg;
    logic               load;

    assign load        = !out_valid_reg || out_ready;
    assign pop         = load && (phase_reg == PH_FIRST) && !empty;

    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign byte_out    = byte_reg;
    assign token_index = index_reg;
    assign last        = last_reg;

    // Phase and valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_FIRST;
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            unique case (phase_reg)
                PH_SECOND:
                begin
                    out_valid_reg <= 1'b1;
                    phase_reg     <= PH_FIRST;
                end
                PH_FIRST:
                begin
                    out_valid_reg <= !empty;
                    if (!empty && rd_job.two)
                    begin
                        phase_reg <= PH_SECOND;
                    end
                end
                default:
                begin
                    phase_reg <= PH_FIRST;
                end
            endcase
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            if (phase_reg == PH_SECOND)
            begin
                kind_reg  <= KIND_DONE;
                byte_reg  <= '0;
                index_reg <= done_idx_reg;
                last_reg  <= 1'b1;
            end
            else if (!empty)
            begin
                kind_reg     <= rd_job.kind0;
                byte_reg     <= rd_job.byte0;
                index_reg    <= rd_job.idx0;
                last_reg     <= !rd_job.two;
                done_idx_reg <= rd_job.idx1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- src/delimiter_tokenizer.sv -----
// ----------------------------------------------------------------------------
// Delimiter tokenizer
// Splits a byte stream into tokens at bytes marked in a 256-bit bitmap.
// ----------------------------------------------------------------------------
// Takes one string byte per transaction on s_axis (tlast marks the end item,
// whose byte is ignored) and emits token bytes, token-end marks and a
// string-done mark on m_axis. A byte input gives at most one result; the end
// item gives a token end and a done mark when a token is open, else a done
// mark alone. Input is taken every cycle while the 4-entry job queue has room;
// results leave at one per cycle while m_axis_tready is high and results are
// pending. The classifier writes the queue at the accepting edge of an item;
// the output register loads the first result of that item from the queue
// when the register holds no result or its held result is taken. The single
// delimiter lookup and scan-state update per byte set the one-byte-per-cycle
// input rate while the queue has room. Configuration writes are always ready
// and take effect at once; write them only while no string is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module delimiter_tokenizer #(
    parameter int COUNT_WIDTH = 16
) (
    input  wire                            clk,
    input  wire                            rst_n,
    // configuration write channel
    input  wire                            cfg_valid,
    output logic                           cfg_ready,
    input  wire [dtok_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire [dtok_pkg::CFG_DATA_W-1:0] cfg_data,
    // string input
    input  wire                            s_axis_tvalid,
    output logic                           s_axis_tready,
    input  wire [7:0]                      s_axis_tdata,   // [7:0] ch
    input  wire                            s_axis_tlast,   // is_end
    // result output
    output logic                           m_axis_tvalid,
    input  wire                            m_axis_tready,
    output logic [23:0]                    m_axis_tdata,   // [7:0] byte_out, [23:8] token_index
    output logic [1:0]                     m_axis_tuser,   // [1:0] kind
    output logic                           m_axis_tlast    // last
);
    import dtok_pkg::*;

    logic              push;
    logic              full;
    logic              empty;
    logic              pop;
    job_t              wr_job;
    job_t              rd_job;
    kind_t             kind;
    logic [BYTE_W-1:0] byte_out;
    logic [IDX_W-1:0]  token_index;

    // Classifier
    dtok_front #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .ch        (s_axis_tdata),
        .is_end    (s_axis_tlast),
        .push      (push),
        .job       (wr_job),
        .full      (full)
    );

    // Job queue
    dtok_fifo u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_job (wr_job),
        .full   (full),
        .pop    (pop),
        .empty  (empty),
        .rd_job (rd_job)
    );

    // Output sequencer
    dtok_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .empty       (empty),
        .rd_job      (rd_job),
        .pop         (pop),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .kind        (kind),
        .byte_out    (byte_out),
        .token_index (token_index),
        .last        (m_axis_tlast)
    );

    assign m_axis_tdata = {token_index, byte_out};
    assign m_axis_tuser = kind;

endmodule

`default_nettype wire

// ----- src/dtok_checker.sv -----
// ----------------------------------------------------------------------------
// Delimiter tokenizer port checker
// Watches the result stream for ordering and payload rules.
// ----------------------------------------------------------------------------
`default_nettype none

`include "delimiter_tokenizer_macros.svh"

module dtok_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [23:0] m_axis_tdata,
    input wire [1:0]  m_axis_tuser,
    input wire        m_axis_tlast
);
    import dtok_pkg::*;

    // stalled result holds
    `DT_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))

    // done mark and token bytes each close their transaction group
    `DT_ASSERT_NOW(a_done_last, m_axis_tvalid && (m_axis_tuser == KIND_DONE || m_axis_tuser == KIND_BYTE), m_axis_tlast)

    // a token end that is not last is followed at once by the done mark
    `DT_ASSERT_NEXT(a_end_then_done, m_axis_tvalid && m_axis_tready && m_axis_tuser == KIND_END && !m_axis_tlast, m_axis_tvalid && m_axis_tuser == KIND_DONE)

    // marks carry a zero byte
    `DT_ASSERT_NOW(a_mark_zero, m_axis_tvalid && m_axis_tuser != KIND_BYTE, m_axis_tdata[7:0] == 8'd0)

endmodule

bind delimiter_tokenizer dtok_checker u_dtok_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
